/* rtl/core/lpp_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register codes, types and width helpers for the line position PID.
package lpp_pkg;

	localparam int SensorCountDefault  = 12;
	localparam int FractionBitsDefault = 8;

	localparam int SensorW   = 12;
	localparam int PosW      = 12;
	localparam int ErrW      = 13;
	localparam int GainW     = 16;
	localparam int ClampW    = 24;
	localparam int GainShift = 8;
	localparam int CfgDataW  = 24;
	localparam int CfgIndexW = 3;

	// integral clamp and steering threshold, whole units before scaling
	localparam int IntegralLimit = 20;
	localparam int SteerPoint    = 4;
	// default setpoint 6.5, kept as a count of halves
	localparam int TargetHalves  = 13;

	typedef enum logic [CfgIndexW-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_OUT_UPPER  = 3'd3,
		REG_OUT_LOWER  = 3'd4,
		REG_TARGET_POS = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [PosW-1:0] position;
		logic            lost;
	} cen_result_t;

	// bits needed for the clamped |error| accumulator
	function automatic int isum_width(input int fb);
		return $clog2((IntegralLimit << fb) + 1);
	endfunction

	// signed operand width shared by |e|, the accumulator and the error difference
	function automatic int oper_width(input int fb);
		int sw;
		sw = isum_width(fb);
		return ((sw > ErrW) ? sw : ErrW) + 1;
	endfunction

	localparam int OperWDefault = oper_width(FractionBitsDefault);

endpackage

/* rtl/core/line_position_pid.sv */
`timescale 1ns / 1ps
// Top level: line position estimate, error, integral and PID drive with output register.
//
//  channel  signals                           direction  beat
//  in       in_valid, in_stall, sensor_bits   receive    one sensor snapshot
//  out      out_valid, out_stall, drive,      send       one PID result
//           position, error, line_lost,
//           steer_left, steer_right
//  cfg      cfg_valid, cfg_ready, cfg_index,  receive    one register write
//           cfg_data
//
// One item at a time: the next snapshot can be taken once the result has been loaded into
// the output register; the one-bit-a-cycle sensor scan, the restoring divider and the 16-step
// multiply-accumulate run back to back, and the result is registered after them.
// A snapshot with no black sensor skips the divider.
// Reset clears all state and loads the register defaults; no clearing pass is needed.
// A stalled result waits in the output register while the next snapshot is taken in.
module line_position_pid #(
	parameter int SENSOR_COUNT  = lpp_pkg::SensorCountDefault,
	parameter int FRACTION_BITS = lpp_pkg::FractionBitsDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [lpp_pkg::SensorW-1:0]          sensor_bits,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [lpp_pkg::ClampW-1:0]    drive,
	output logic [lpp_pkg::PosW-1:0]             position,
	output logic signed [lpp_pkg::ErrW-1:0]      error,
	output logic                                 line_lost,
	output logic                                 steer_left,
	output logic                                 steer_right,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lpp_pkg::CfgIndexW-1:0]        cfg_index,
	input  logic [lpp_pkg::CfgDataW-1:0]         cfg_data
);

	localparam int SumIW     = lpp_pkg::isum_width(FRACTION_BITS);
	localparam int OperW     = lpp_pkg::oper_width(FRACTION_BITS);
	localparam int ProdW     = OperW + lpp_pkg::GainW + 3;
	localparam int ShW       = ProdW - lpp_pkg::GainShift;
	localparam int CmpW      = (ShW > lpp_pkg::ClampW) ? ShW : lpp_pkg::ClampW;
	localparam int SumW      = ((SumIW > lpp_pkg::ErrW) ? SumIW : lpp_pkg::ErrW) + 1;
	localparam int SteerCmpW = lpp_pkg::PosW + 5;

	localparam logic [SumIW-1:0] LimitVal =
		SumIW'(lpp_pkg::IntegralLimit << FRACTION_BITS);
	localparam logic [SteerCmpW-1:0] SteerLevel =
		SteerCmpW'(lpp_pkg::SteerPoint << FRACTION_BITS);
	localparam logic [lpp_pkg::PosW-1:0] TargetReset =
		lpp_pkg::PosW'((lpp_pkg::TargetHalves << FRACTION_BITS) >> 1);

	typedef enum logic [2:0] {
		T_IDLE,
		T_CENTROID,
		T_ERROR,
		T_MAC,
		T_FINISH
	} top_state_t;

	top_state_t                          state_q;

	logic signed [lpp_pkg::GainW-1:0]    gain_p_q;
	logic signed [lpp_pkg::GainW-1:0]    gain_i_q;
	logic signed [lpp_pkg::GainW-1:0]    gain_d_q;
	logic signed [lpp_pkg::ClampW-1:0]   upper_q;
	logic signed [lpp_pkg::ClampW-1:0]   lower_q;
	logic [lpp_pkg::PosW-1:0]            target_q;

	logic [lpp_pkg::PosW-1:0]            held_q;
	logic [SumIW-1:0]                    abs_sum_q;
	logic signed [lpp_pkg::ErrW-1:0]     prev_q;
	logic                                left_q;
	logic                                right_q;

	logic [lpp_pkg::PosW-1:0]            pos_q;
	logic                                lost_q;
	logic signed [lpp_pkg::ErrW-1:0]     err_q;
	logic signed [OperW-1:0]             mag_q;
	logic signed [OperW-1:0]             isum_q;
	logic signed [OperW-1:0]             diff_q;
	logic                                mac_go_q;

	logic                                out_valid_q;
	logic signed [lpp_pkg::ClampW-1:0]   drive_q;
	logic [lpp_pkg::PosW-1:0]            out_pos_q;
	logic signed [lpp_pkg::ErrW-1:0]     out_err_q;
	logic                                out_lost_q;
	logic                                out_left_q;
	logic                                out_right_q;

	logic                                accept;
	logic                                cen_done;
	lpp_pkg::cen_result_t                cen_result;
	logic                                mac_done;
	logic signed [ProdW-1:0]             mac_product;

	logic signed [lpp_pkg::ErrW-1:0]     err;
	logic [lpp_pkg::ErrW-1:0]            mag;
	logic [SumW-1:0]                     sum_full;
	logic [SumIW-1:0]                    isum_nx;
	logic signed [lpp_pkg::ErrW:0]       diff;
	logic [SteerCmpW-1:0]                pos_wide;

	logic signed [ShW-1:0]               sh;
	logic signed [CmpW-1:0]              v0;
	logic signed [CmpW-1:0]              upper_ext;
	logic signed [CmpW-1:0]              lower_ext;
	logic signed [CmpW-1:0]              v1;
	logic signed [CmpW-1:0]              v2;
	logic signed [lpp_pkg::ClampW-1:0]   drive_nx;

	assign in_stall  = (state_q != T_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	lpp_centroid #(
		.SENSOR_COUNT  (SENSOR_COUNT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_centroid (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.sensor_bits (sensor_bits),
		.done        (cen_done),
		.result      (cen_result)
	);

	lpp_mac #(
		.OPER_W (OperW)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mac_go_q),
		.gain_p  (gain_p_q),
		.gain_i  (gain_i_q),
		.gain_d  (gain_d_q),
		.oper_p  (mag_q),
		.oper_i  (isum_q),
		.oper_d  (diff_q),
		.done    (mac_done),
		.product (mac_product)
	);

	always_comb begin
		err      = lpp_pkg::ErrW'(lpp_pkg::ErrW'(target_q) - lpp_pkg::ErrW'(pos_q));
		mag      = err[lpp_pkg::ErrW-1] ? lpp_pkg::ErrW'(-err) : lpp_pkg::ErrW'(err);
		sum_full = SumW'(abs_sum_q) + SumW'(mag);
		isum_nx  = (sum_full > SumW'(LimitVal)) ? LimitVal : sum_full[SumIW-1:0];
		diff     = (lpp_pkg::ErrW+1)'(err) - (lpp_pkg::ErrW+1)'(prev_q);
		pos_wide = SteerCmpW'(pos_q);

		// floor shift of the Q8.8 gain scaling, upper clamp, then lower clamp
		sh        = mac_product[ProdW-1:lpp_pkg::GainShift];
		v0        = CmpW'(sh);
		upper_ext = CmpW'(upper_q);
		lower_ext = CmpW'(lower_q);
		v1        = (v0 > upper_ext) ? upper_ext : v0;
		v2        = (v1 < lower_ext) ? lower_ext : v1;
		drive_nx  = v2[lpp_pkg::ClampW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			gain_p_q    <= lpp_pkg::GainW'(256);
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			upper_q     <= {1'b0, {(lpp_pkg::ClampW-1){1'b1}}};
			lower_q     <= {1'b1, {(lpp_pkg::ClampW-1){1'b0}}};
			target_q    <= TargetReset;
			held_q      <= '0;
			abs_sum_q   <= '0;
			prev_q      <= '0;
			left_q      <= 1'b0;
			right_q     <= 1'b0;
			pos_q       <= '0;
			lost_q      <= 1'b0;
			err_q       <= '0;
			mag_q       <= '0;
			isum_q      <= '0;
			diff_q      <= '0;
			mac_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			out_pos_q   <= '0;
			out_err_q   <= '0;
			out_lost_q  <= 1'b0;
			out_left_q  <= 1'b0;
			out_right_q <= 1'b0;
		end else begin
			mac_go_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (lpp_pkg::cfg_reg_t'(cfg_index))
					lpp_pkg::REG_GAIN_P:     gain_p_q <= cfg_data[lpp_pkg::GainW-1:0];
					lpp_pkg::REG_GAIN_I:     gain_i_q <= cfg_data[lpp_pkg::GainW-1:0];
					lpp_pkg::REG_GAIN_D:     gain_d_q <= cfg_data[lpp_pkg::GainW-1:0];
					lpp_pkg::REG_OUT_UPPER:  upper_q  <= cfg_data[lpp_pkg::ClampW-1:0];
					lpp_pkg::REG_OUT_LOWER:  lower_q  <= cfg_data[lpp_pkg::ClampW-1:0];
					lpp_pkg::REG_TARGET_POS: target_q <= cfg_data[lpp_pkg::PosW-1:0];
					default: begin
					end
				endcase
			end

			// drop the result once the beat is taken; the finish step reloads it itself
			if (out_valid_q && !out_stall && state_q != T_FINISH) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_CENTROID;
					end
				end
				T_CENTROID: begin
					if (cen_done) begin
						lost_q <= cen_result.lost;
						if (cen_result.lost) begin
							pos_q <= held_q;
						end else begin
							pos_q  <= cen_result.position;
							held_q <= cen_result.position;
						end
						state_q <= T_ERROR;
					end
				end
				T_ERROR: begin
					err_q  <= err;
					mag_q  <= OperW'(mag);
					isum_q <= OperW'(isum_nx);
					diff_q <= OperW'(diff);
					prev_q <= err;
					// integral uses the updated sum, then clears on zero error
					abs_sum_q <= (err == '0) ? '0 : isum_nx;
					if (pos_wide > SteerLevel) begin
						left_q  <= 1'b0;
						right_q <= 1'b1;
					end else if (pos_wide < SteerLevel) begin
						left_q  <= 1'b1;
						right_q <= 1'b0;
					end
					mac_go_q <= 1'b1;
					state_q  <= T_MAC;
				end
				T_MAC: begin
					if (mac_done) begin
						state_q <= T_FINISH;
					end
				end
				T_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						drive_q     <= drive_nx;
						out_pos_q   <= pos_q;
						out_err_q   <= err_q;
						out_lost_q  <= lost_q;
						out_left_q  <= left_q;
						out_right_q <= right_q;
						state_q     <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign drive       = drive_q;
	assign position    = out_pos_q;
	assign error       = out_err_q;
	assign line_lost   = out_lost_q;
	assign steer_left  = out_left_q;
	assign steer_right = out_right_q;

`ifndef ASSERT_OFF
	a_accept_blocks : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("snapshot accepted but the block kept taking input");

	a_result_from_finish : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == T_FINISH))
		else $error("result raised outside the finish step");

	a_integral_bound : assert property (@(posedge clk) disable iff (!arst_n)
		abs_sum_q <= LimitVal)
		else $error("error accumulator above its clamp");

	a_steer_exclusive : assert property (@(posedge clk) disable iff (!arst_n)
		!(left_q && right_q))
		else $error("both steering marks set");

	a_centroid_timing : assert property (@(posedge clk) disable iff (!arst_n)
		cen_done |-> state_q == T_CENTROID)
		else $error("centroid finished while no item waited for it");
`endif

endmodule

/* rtl/core/lpp_centroid.sv */
`timescale 1ns / 1ps
// Bit-serial sensor scan and restoring divider for the weighted line centroid.
module lpp_centroid #(
	parameter int SENSOR_COUNT  = lpp_pkg::SensorCountDefault,
	parameter int FRACTION_BITS = lpp_pkg::FractionBitsDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lpp_pkg::SensorW-1:0]  sensor_bits,
	output logic                         done,
	output lpp_pkg::cen_result_t         result
);

	localparam int CntW  = $clog2(SENSOR_COUNT + 1);
	localparam int WsumW = $clog2(SENSOR_COUNT * (SENSOR_COUNT + 1) / 2 + 1);
	localparam int DvdW  = WsumW + FRACTION_BITS;
	localparam int StepW = $clog2(DvdW);

	typedef enum logic [1:0] {
		C_IDLE,
		C_SCAN,
		C_DIVIDE
	} cen_state_t;

	cen_state_t                          state_q;
	logic [SENSOR_COUNT-1:0]             bits_q;
	logic [CntW-1:0]                     idx_q;
	logic [CntW-1:0]                     count_q;
	logic [CntW-1:0]                     rem_q;
	logic [WsumW-1:0]                    wsum_q;
	logic [DvdW-1:0]                     dvd_q;
	logic [StepW-1:0]                    step_q;
	logic                                done_q;
	lpp_pkg::cen_result_t                result_q;

	logic [lpp_pkg::SensorW+SENSOR_COUNT-1:0] bits_ext;
	logic [CntW-1:0]                     count_nx;
	logic [WsumW-1:0]                    wsum_nx;
	logic [CntW:0]                       trial;
	logic                                take;
	logic [DvdW-1:0]                     dvd_nx;
	logic [lpp_pkg::PosW+DvdW-1:0]       quot_ext;

	always_comb begin
		bits_ext = {{SENSOR_COUNT{1'b0}}, sensor_bits};
		count_nx = bits_q[0] ? count_q + CntW'(1) : count_q;
		wsum_nx  = bits_q[0] ? wsum_q + WsumW'(idx_q) : wsum_q;
		// one quotient bit a cycle: shift in the next dividend bit, subtract if it fits
		trial    = {rem_q, dvd_q[DvdW-1]};
		take     = (trial >= {1'b0, count_q});
		dvd_nx   = {dvd_q[DvdW-2:0], take};
		quot_ext = {{lpp_pkg::PosW{1'b0}}, dvd_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= C_IDLE;
			bits_q   <= '0;
			idx_q    <= '0;
			count_q  <= '0;
			rem_q    <= '0;
			wsum_q   <= '0;
			dvd_q    <= '0;
			step_q   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						bits_q  <= bits_ext[SENSOR_COUNT-1:0];
						idx_q   <= CntW'(1);
						count_q <= '0;
						wsum_q  <= '0;
						state_q <= C_SCAN;
					end
				end
				C_SCAN: begin
					bits_q  <= bits_q >> 1;
					idx_q   <= idx_q + CntW'(1);
					count_q <= count_nx;
					wsum_q  <= wsum_nx;
					if (idx_q == CntW'(SENSOR_COUNT)) begin
						if (count_nx == '0) begin
							// no black sensor: report lost, skip the divide
							result_q.position <= '0;
							result_q.lost     <= 1'b1;
							done_q            <= 1'b1;
							state_q           <= C_IDLE;
						end else begin
							dvd_q   <= {wsum_nx, {FRACTION_BITS{1'b0}}};
							rem_q   <= '0;
							step_q  <= '0;
							state_q <= C_DIVIDE;
						end
					end
				end
				C_DIVIDE: begin
					dvd_q  <= dvd_nx;
					rem_q  <= take ? CntW'(trial - {1'b0, count_q}) : trial[CntW-1:0];
					step_q <= step_q + StepW'(1);
					if (step_q == StepW'(DvdW - 1)) begin
						result_q.position <= quot_ext[lpp_pkg::PosW-1:0];
						result_q.lost     <= 1'b0;
						done_q            <= 1'b1;
						state_q           <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* rtl/core/lpp_mac.sv */
`timescale 1ns / 1ps
// Bit-serial signed multiply-accumulate of three gains against three operands.
module lpp_mac #(
	parameter int OPER_W = lpp_pkg::OperWDefault
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic signed [lpp_pkg::GainW-1:0]             gain_p,
	input  logic signed [lpp_pkg::GainW-1:0]             gain_i,
	input  logic signed [lpp_pkg::GainW-1:0]             gain_d,
	input  logic signed [OPER_W-1:0]                     oper_p,
	input  logic signed [OPER_W-1:0]                     oper_i,
	input  logic signed [OPER_W-1:0]                     oper_d,
	output logic                                         done,
	output logic signed [OPER_W+lpp_pkg::GainW+2:0]      product
);

	localparam int TermW = OPER_W + 2;
	localparam int HiW   = TermW + 1;
	localparam int StepW = $clog2(lpp_pkg::GainW);

	logic                          busy_q;
	logic                          done_q;
	logic [StepW-1:0]              step_q;
	logic signed [HiW-1:0]         hi_q;
	logic [lpp_pkg::GainW-1:0]     lo_q;

	logic signed [TermW-1:0]       term;
	logic signed [HiW:0]           hi_ext;
	logic signed [HiW:0]           term_ext;
	logic signed [HiW:0]           sum;
	logic                          last;

	always_comb begin
		term = (gain_p[step_q] ? TermW'(oper_p) : TermW'(0))
		     + (gain_i[step_q] ? TermW'(oper_i) : TermW'(0))
		     + (gain_d[step_q] ? TermW'(oper_d) : TermW'(0));
		last     = (step_q == StepW'(lpp_pkg::GainW - 1));
		hi_ext   = (HiW+1)'(hi_q);
		term_ext = (HiW+1)'(term);
		// the gain sign bit weighs negative
		sum      = last ? hi_ext - term_ext : hi_ext + term_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				hi_q   <= '0;
				lo_q   <= '0;
			end else if (busy_q) begin
				// add, then shift one product bit down into the low word
				hi_q   <= sum[HiW:1];
				lo_q   <= {sum[0], lo_q[lpp_pkg::GainW-1:1]};
				step_q <= step_q + StepW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule
